/* design/hrhp_pkg.sv */
// Package for the HTTP request header parser: parser phases, result codes,
// keyword text and the packed parser state. No dependencies.
package hrhp_pkg;

    // Default width of the Content-Length accumulator.
    localparam int LENGTH_BITS_DEF = 32;
    // Widest accumulator supported; used to saturate the 32-bit output.
    localparam int LENGTH_BITS_MAX = 64;
    // Depth of the result queue; holds two beats of one byte plus slack.
    localparam int RES_DEPTH = 4;

    // Parser phases.
    typedef enum logic [2:0] {
        PH_METHOD  = 3'd0,
        PH_TARGET  = 3'd1,
        PH_VERSION = 3'd2,
        PH_KEY     = 3'd3,
        PH_VSKIP   = 3'd4,
        PH_VALUE   = 3'd5
    } t_phase;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_TARGET  = 2'd1,
        KIND_HOST    = 2'd2,
        KIND_RESTART = 2'd3
    } t_kind;

    // Completion status.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD     = 2'd1,
        ST_VERSION = 2'd2
    } t_status;

    // Method codes.
    typedef enum logic [1:0] {
        METH_GET     = 2'd0,
        METH_HEAD    = 2'd1,
        METH_UNKNOWN = 2'd2
    } t_method;

    // Bit positions in the key candidate mask.
    localparam int KEY_HOST = 0;
    localparam int KEY_CONN = 1;
    localparam int KEY_CLEN = 2;

    // Bit positions in the match flags.
    localparam int FLAG_A = 0;
    localparam int FLAG_B = 1;
    localparam int FLAG_C = 2;

    // Special characters.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Keyword text, last character in the low byte.
    localparam int          TXT_BITS  = 112;
    localparam logic [23:0]  STR_GET   = "GET";
    localparam logic [31:0]  STR_HEAD  = "HEAD";
    localparam logic [63:0]  STR_VER   = "HTTP/1.1";
    localparam logic [39:0]  STR_CLOSE = "close";
    localparam logic [31:0]  STR_HOST  = "Host";
    localparam logic [79:0]  STR_CONN  = "Connection";
    localparam logic [111:0] STR_CLEN  = "Content-Length";
    localparam logic [3:0]   LEN_GET   = 4'd3;
    localparam logic [3:0]   LEN_HEAD  = 4'd4;
    localparam logic [3:0]   LEN_VER   = 4'd8;
    localparam logic [3:0]   LEN_CLOSE = 4'd5;
    localparam logic [3:0]   LEN_HOST  = 4'd4;
    localparam logic [3:0]   LEN_CONN  = 4'd10;
    localparam logic [3:0]   LEN_CLEN  = 4'd14;

    // Parser state apart from the length accumulator.
    typedef struct packed {
        t_phase      phase;
        logic        cr_pending;
        logic [3:0]  match_pos;
        logic [2:0]  key_cand;
        logic [2:0]  flags;
        t_method     method;
        logic        close_flag;
        logic        finished;
    } t_pstate;

    // Character at a position of a keyword; NUL past its end.
    function automatic logic [7:0] f_pick(input logic [TXT_BITS-1:0] txt,
                                          input logic [3:0] len,
                                          input logic [3:0] pos);
        logic [6:0]          sh_amt;
        logic [TXT_BITS-1:0] shifted;
        sh_amt  = {4'(len - 4'd1 - pos), 3'b000};
        shifted = txt >> sh_amt;
        return (pos < len) ? shifted[7:0] : CH_NUL;
    endfunction

    // Saturating increment of the match position.
    function automatic logic [3:0] f_bump(input logic [3:0] pos);
        return (pos == 4'hF) ? pos : pos + 4'd1;
    endfunction

    // State after reset or a start flag.
    function automatic t_pstate f_reset_state();
        t_pstate s;
        s.phase      = PH_METHOD;
        s.cr_pending = 1'b0;
        s.match_pos  = 4'd0;
        s.key_cand   = 3'b111;
        s.flags      = 3'b000;
        s.method     = METH_UNKNOWN;
        s.close_flag = 1'b0;
        s.finished   = 1'b0;
        return s;
    endfunction

endpackage

/* design/hrhp_if.sv */
// Handshake interfaces for request byte beats and parser result beats.
// Depends on hrhp_pkg for the result code types.
interface hrhp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       start_req;

    modport source (output valid, output in_byte, output start_req, input ready);
    modport sink   (input valid, input in_byte, input start_req, output ready);
endinterface

interface hrhp_res_if;
    logic               valid;
    logic               ready;
    hrhp_pkg::t_kind    kind;
    logic [7:0]         out_byte;
    logic               last;
    logic               done_res;
    hrhp_pkg::t_status  status;
    hrhp_pkg::t_method  method;
    logic               conn_close;
    logic [31:0]        body_len;

    modport source (output valid, output kind, output out_byte, output last,
                    output done_res, output status, output method,
                    output conn_close, output body_len, input ready);
    modport sink   (input valid, input kind, input out_byte, input last,
                    input done_res, input status, input method,
                    input conn_close, input body_len, output ready);
endinterface

/* design/http_request_header_parser_core.sv */
// HTTP/1.1 request line and header parser, one request byte per beat.
// Depends on hrhp_pkg and the interfaces in hrhp_if.sv.
//
// Channel   Dir  Beat contents
// i_byte    in   in_byte, start_req
// o_res     out  kind, out_byte, last, done_res, status, method,
//                conn_close, body_len
//
// A byte beat is registered, parsed once the queue has room for two result
// beats, and written into a four-entry result queue.
// One byte is taken per cycle while o_res is not stalled and each byte gives one
// result; a byte that replays a held-back CR inside a Host value gives two result
// beats, and the one-beat-per-cycle read port of the result queue then sets the pace.
// Reset is synchronous and active low and clears the parser state and the queue.
// A stall on o_res fills the queue, and i_byte.ready drops once fewer than
// two queue entries are free.
module http_request_header_parser_core #(
    parameter int LENGTH_BITS = hrhp_pkg::LENGTH_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    hrhp_byte_if.sink          i_byte,
    hrhp_res_if.source         o_res
);

    localparam int DEPTH = hrhp_pkg::RES_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef struct packed {
        hrhp_pkg::t_pstate      st;
        logic [LENGTH_BITS-1:0] acc;
    } t_full;

    typedef struct packed {
        hrhp_pkg::t_kind   kind;
        logic [7:0]        out_byte;
        logic              last;
        logic              done_res;
        hrhp_pkg::t_status status;
        hrhp_pkg::t_method method;
        logic              conn_close;
        logic [31:0]       body_len;
    } t_res;

    // Content-Length accumulator saturated to the 32-bit output.
    function automatic logic [31:0] f_sat32(input logic [LENGTH_BITS-1:0] acc);
        logic [hrhp_pkg::LENGTH_BITS_MAX-1:0] ext;
        ext = hrhp_pkg::LENGTH_BITS_MAX'(acc);
        return (|ext[hrhp_pkg::LENGTH_BITS_MAX-1:32]) ? 32'hFFFF_FFFF : ext[31:0];
    endfunction

    // One byte of a header value.
    function automatic t_full f_value(input t_full f, input logic [7:0] c,
                                      output hrhp_pkg::t_kind k);
        t_full                  r;
        logic [LENGTH_BITS+3:0] prod;
        r = f;
        k = hrhp_pkg::KIND_NONE;
        prod = {3'b000, f.acc, 1'b0} + {1'b0, f.acc, 3'b000}
             + (LENGTH_BITS+4)'(c - hrhp_pkg::CH_ZERO);
        if (f.st.key_cand[hrhp_pkg::KEY_HOST]) begin
            k = hrhp_pkg::KIND_HOST;
        end else begin
            // Connection value compared against "close".
            if (f.st.key_cand[hrhp_pkg::KEY_CONN]) begin
                if (c != hrhp_pkg::f_pick(hrhp_pkg::TXT_BITS'(hrhp_pkg::STR_CLOSE),
                                          hrhp_pkg::LEN_CLOSE, f.st.match_pos)) begin
                    r.st.flags[hrhp_pkg::FLAG_B] = 1'b1;
                end
                r.st.match_pos = hrhp_pkg::f_bump(f.st.match_pos);
            end
            // Content-Length leading digits, saturating.
            if (f.st.key_cand[hrhp_pkg::KEY_CLEN]) begin
                if (!f.st.flags[hrhp_pkg::FLAG_C] && c >= hrhp_pkg::CH_ZERO
                        && c <= hrhp_pkg::CH_NINE) begin
                    r.acc = (|prod[LENGTH_BITS+3:LENGTH_BITS]) ? '1
                                                               : prod[LENGTH_BITS-1:0];
                end else begin
                    r.st.flags[hrhp_pkg::FLAG_C] = 1'b1;
                end
            end
        end
        return r;
    endfunction

    // One ordinary byte in the current phase.
    function automatic t_full f_plain(input t_full f, input logic [7:0] c,
                                      output hrhp_pkg::t_kind k);
        t_full      r;
        logic [2:0] sel;
        logic [7:0] kc_host;
        logic [7:0] kc_conn;
        logic [7:0] kc_clen;
        r = f;
        k = hrhp_pkg::KIND_NONE;
        sel = 3'b000;
        kc_host = hrhp_pkg::f_pick(hrhp_pkg::TXT_BITS'(hrhp_pkg::STR_HOST),
                                   hrhp_pkg::LEN_HOST, f.st.match_pos);
        kc_conn = hrhp_pkg::f_pick(hrhp_pkg::TXT_BITS'(hrhp_pkg::STR_CONN),
                                   hrhp_pkg::LEN_CONN, f.st.match_pos);
        kc_clen = hrhp_pkg::f_pick(hrhp_pkg::TXT_BITS'(hrhp_pkg::STR_CLEN),
                                   hrhp_pkg::LEN_CLEN, f.st.match_pos);
        unique case (f.st.phase)
            hrhp_pkg::PH_METHOD: begin
                if (c == hrhp_pkg::CH_SP) begin
                    if (f.st.match_pos == hrhp_pkg::LEN_GET
                            && !f.st.flags[hrhp_pkg::FLAG_A]) begin
                        r.st.method = hrhp_pkg::METH_GET;
                    end else if (f.st.match_pos == hrhp_pkg::LEN_HEAD
                            && !f.st.flags[hrhp_pkg::FLAG_B]) begin
                        r.st.method = hrhp_pkg::METH_HEAD;
                    end else begin
                        r.st.method = hrhp_pkg::METH_UNKNOWN;
                    end
                    r.st.phase     = hrhp_pkg::PH_TARGET;
                    r.st.match_pos = 4'd0;
                    r.st.flags     = 3'b000;
                end else begin
                    if (c != hrhp_pkg::f_pick(hrhp_pkg::TXT_BITS'(hrhp_pkg::STR_GET),
                                              hrhp_pkg::LEN_GET, f.st.match_pos)) begin
                        r.st.flags[hrhp_pkg::FLAG_A] = 1'b1;
                    end
                    if (c != hrhp_pkg::f_pick(hrhp_pkg::TXT_BITS'(hrhp_pkg::STR_HEAD),
                                              hrhp_pkg::LEN_HEAD, f.st.match_pos)) begin
                        r.st.flags[hrhp_pkg::FLAG_B] = 1'b1;
                    end
                    r.st.match_pos = hrhp_pkg::f_bump(f.st.match_pos);
                end
            end
            hrhp_pkg::PH_TARGET: begin
                if (c == hrhp_pkg::CH_SP) begin
                    r.st.phase     = hrhp_pkg::PH_VERSION;
                    r.st.match_pos = 4'd0;
                    r.st.flags     = 3'b000;
                end else begin
                    k = hrhp_pkg::KIND_TARGET;
                end
            end
            hrhp_pkg::PH_VERSION: begin
                if (f.st.match_pos < hrhp_pkg::LEN_VER
                        && c != hrhp_pkg::f_pick(hrhp_pkg::TXT_BITS'(hrhp_pkg::STR_VER),
                                                 hrhp_pkg::LEN_VER, f.st.match_pos)) begin
                    r.st.flags[hrhp_pkg::FLAG_A] = 1'b1;
                end
                r.st.match_pos = hrhp_pkg::f_bump(f.st.match_pos);
            end
            hrhp_pkg::PH_KEY: begin
                if (c == hrhp_pkg::CH_COLON) begin
                    // Pick the one key whose full length was matched.
                    if (f.st.key_cand[hrhp_pkg::KEY_HOST]
                            && f.st.match_pos == hrhp_pkg::LEN_HOST) begin
                        sel = 3'b001;
                    end
                    if (f.st.key_cand[hrhp_pkg::KEY_CONN]
                            && f.st.match_pos == hrhp_pkg::LEN_CONN) begin
                        sel = 3'b010;
                    end
                    if (f.st.key_cand[hrhp_pkg::KEY_CLEN]
                            && f.st.match_pos == hrhp_pkg::LEN_CLEN) begin
                        sel = 3'b100;
                    end
                    r.st.key_cand  = sel;
                    r.st.match_pos = 4'd0;
                    r.st.flags     = 3'b000;
                    r.st.phase     = hrhp_pkg::PH_VSKIP;
                    if (sel[hrhp_pkg::KEY_CLEN]) begin
                        r.acc = '0;
                    end
                    if (sel[hrhp_pkg::KEY_HOST]) begin
                        k = hrhp_pkg::KIND_RESTART;
                    end
                end else begin
                    if (c != kc_host) r.st.key_cand[hrhp_pkg::KEY_HOST] = 1'b0;
                    if (c != kc_conn) r.st.key_cand[hrhp_pkg::KEY_CONN] = 1'b0;
                    if (c != kc_clen) r.st.key_cand[hrhp_pkg::KEY_CLEN] = 1'b0;
                    r.st.match_pos = hrhp_pkg::f_bump(f.st.match_pos);
                end
            end
            hrhp_pkg::PH_VSKIP: begin
                if (c != hrhp_pkg::CH_SP) begin
                    r.st.phase = hrhp_pkg::PH_VALUE;
                    r = f_value(r, c, k);
                end
            end
            hrhp_pkg::PH_VALUE: begin
                r = f_value(f, c, k);
            end
            default: begin
                r = f;
            end
        endcase
        return r;
    endfunction

    // Line ended by CR LF.
    function automatic t_full f_line_end(input t_full f, output logic done,
                                         output hrhp_pkg::t_status st);
        t_full r;
        r = f;
        done = 1'b0;
        st = hrhp_pkg::ST_OK;
        unique case (f.st.phase)
            hrhp_pkg::PH_VERSION: begin
                if (f.st.match_pos < hrhp_pkg::LEN_VER || f.st.flags[hrhp_pkg::FLAG_A]) begin
                    done = 1'b1;
                    st = hrhp_pkg::ST_VERSION;
                end
            end
            hrhp_pkg::PH_KEY: begin
                done = 1'b1;
                st = (f.st.match_pos == 4'd0) ? hrhp_pkg::ST_OK : hrhp_pkg::ST_BAD;
            end
            hrhp_pkg::PH_VSKIP, hrhp_pkg::PH_VALUE: begin
                if (f.st.key_cand[hrhp_pkg::KEY_CONN]) begin
                    r.st.close_flag = !f.st.flags[hrhp_pkg::FLAG_B]
                                      && f.st.match_pos == hrhp_pkg::LEN_CLOSE;
                end
            end
            default: begin
                r = f;
            end
        endcase
        r.st.finished = done;
        // Every line end that does not finish starts a new header key.
        if (!done && f.st.phase != hrhp_pkg::PH_METHOD
                && f.st.phase != hrhp_pkg::PH_TARGET) begin
            r.st.phase     = hrhp_pkg::PH_KEY;
            r.st.match_pos = 4'd0;
            r.st.key_cand  = 3'b111;
            r.st.flags     = 3'b000;
        end
        return r;
    endfunction

    // Input register.
    logic                   r_in_valid;
    logic [7:0]             r_in_byte;
    logic                   r_in_start;

    // Parser state.
    hrhp_pkg::t_pstate      r_st;
    logic [LENGTH_BITS-1:0] r_acc;

    // Result queue.
    t_res                   r_mem [DEPTH];
    logic [PTR_W-1:0]       r_wptr;
    logic [PTR_W-1:0]       r_rptr;
    logic [CNT_W-1:0]       r_cnt;
    logic [CNT_W-1:0]       n_cnt;

    // Step signals.
    logic                   w_proc;
    logic                   w_pop;
    logic                   w_two;
    t_full                  w_cur;
    t_full                  w_mid;
    t_full                  w_tmp;
    t_full                  n_full;
    hrhp_pkg::t_kind        w_k0;
    hrhp_pkg::t_kind        w_k1;
    logic                   w_done;
    hrhp_pkg::t_status      w_stat;
    t_res                   w_res0;
    t_res                   w_res1;

    // A byte is parsed when the queue has room for two result beats.
    assign w_proc       = r_in_valid && (r_cnt <= CNT_W'(DEPTH - 2));
    assign w_pop        = o_res.valid && o_res.ready;
    assign i_byte.ready = !r_in_valid || w_proc;

    // Input register load.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.valid && i_byte.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_in_byte  <= i_byte.in_byte;
            r_in_start <= i_byte.start_req;
        end
    end

    // Next parser state: held-back CR replay, then the current byte.
    always_comb begin
        w_cur.st  = r_in_start ? hrhp_pkg::f_reset_state() : r_st;
        w_cur.acc = r_in_start ? '0 : r_acc;
        w_mid     = w_cur;
        w_tmp     = w_cur;
        n_full    = w_cur;
        w_two     = 1'b0;
        w_k0      = hrhp_pkg::KIND_NONE;
        w_k1      = hrhp_pkg::KIND_NONE;
        w_done    = 1'b0;
        w_stat    = hrhp_pkg::ST_OK;
        if (w_cur.st.finished) begin
            n_full = w_cur;
        end else if (r_in_byte == hrhp_pkg::CH_NUL) begin
            // End of buffer before the parse ended.
            n_full.st.cr_pending = 1'b0;
            n_full.st.finished   = 1'b1;
            w_done = 1'b1;
            w_stat = hrhp_pkg::ST_BAD;
        end else if (w_cur.st.phase != hrhp_pkg::PH_METHOD
                && w_cur.st.phase != hrhp_pkg::PH_TARGET) begin
            if (w_cur.st.cr_pending) begin
                w_tmp.st.cr_pending = 1'b0;
                if (r_in_byte == hrhp_pkg::CH_LF) begin
                    n_full = f_line_end(w_tmp, w_done, w_stat);
                end else begin
                    w_mid = f_plain(w_tmp, hrhp_pkg::CH_CR, w_k0);
                    w_two = (w_k0 != hrhp_pkg::KIND_NONE);
                    if (r_in_byte == hrhp_pkg::CH_CR) begin
                        n_full = w_mid;
                        n_full.st.cr_pending = 1'b1;
                    end else begin
                        n_full = f_plain(w_mid, r_in_byte, w_k1);
                    end
                end
            end else if (r_in_byte == hrhp_pkg::CH_CR) begin
                n_full.st.cr_pending = 1'b1;
            end else begin
                n_full = f_plain(w_cur, r_in_byte, w_k1);
            end
        end else begin
            n_full = f_plain(w_cur, r_in_byte, w_k1);
        end
    end

    // Result beats of the step.
    always_comb begin
        w_res0.kind             = w_k0;
        w_res0.out_byte         = (w_k0 == hrhp_pkg::KIND_HOST) ? hrhp_pkg::CH_CR
                                                                : hrhp_pkg::CH_NUL;
        w_res0.last             = 1'b0;
        w_res0.done_res         = 1'b0;
        w_res0.status           = hrhp_pkg::ST_OK;
        w_res0.method           = w_mid.st.method;
        w_res0.conn_close       = w_mid.st.close_flag;
        w_res0.body_len         = f_sat32(w_mid.acc);

        w_res1.kind             = w_k1;
        w_res1.out_byte         = (w_k1 == hrhp_pkg::KIND_TARGET
                                   || w_k1 == hrhp_pkg::KIND_HOST) ? r_in_byte
                                                                   : hrhp_pkg::CH_NUL;
        w_res1.last             = 1'b1;
        w_res1.done_res         = w_done;
        w_res1.status           = w_stat;
        w_res1.method           = n_full.st.method;
        w_res1.conn_close       = n_full.st.close_flag;
        w_res1.body_len         = f_sat32(n_full.acc);
    end

    // Parser state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= hrhp_pkg::f_reset_state();
            r_acc <= '0;
        end else if (w_proc) begin
            r_st  <= n_full.st;
            r_acc <= n_full.acc;
        end
    end

    // Result queue storage.
    always_ff @(posedge i_clk) begin
        if (w_proc) begin
            if (w_two) begin
                r_mem[r_wptr]                 <= w_res0;
                r_mem[PTR_W'(r_wptr + 1'b1)]  <= w_res1;
            end else begin
                r_mem[r_wptr] <= w_res1;
            end
        end
    end

    // Result queue pointers and fill count.
    always_comb begin
        n_cnt = r_cnt;
        if (w_proc) begin
            n_cnt = n_cnt + (w_two ? CNT_W'(2) : CNT_W'(1));
        end
        if (w_pop) begin
            n_cnt = n_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_proc) begin
                r_wptr <= r_wptr + (w_two ? PTR_W'(2) : PTR_W'(1));
            end
            if (w_pop) begin
                r_rptr <= r_rptr + PTR_W'(1);
            end
            r_cnt <= n_cnt;
        end
    end

    // Output beat from the queue head.
    assign o_res.valid            = (r_cnt != '0);
    assign o_res.kind             = r_mem[r_rptr].kind;
    assign o_res.out_byte         = r_mem[r_rptr].out_byte;
    assign o_res.last             = r_mem[r_rptr].last;
    assign o_res.done_res         = r_mem[r_rptr].done_res;
    assign o_res.status           = r_mem[r_rptr].status;
    assign o_res.method           = r_mem[r_rptr].method;
    assign o_res.conn_close       = r_mem[r_rptr].conn_close;
    assign o_res.body_len         = r_mem[r_rptr].body_len;

`ifndef SYNTHESIS
    // The queue never holds more beats than it has entries.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("result queue count above depth");

    // A two-beat step only happens for a replayed CR inside a Host value.
    a_two_host: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && w_two) |-> (w_k0 == hrhp_pkg::KIND_HOST))
        else $error("two-beat step without a Host value byte");

    // A finishing step leaves the parser finished.
    a_done_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && w_done) |=> r_st.finished)
        else $error("parser not finished after done");

    // The fill count holds still when there is neither a push nor a pop.
    a_cnt_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_proc && !w_pop) |=> $stable(r_cnt))
        else $error("result queue count changed without traffic");
`endif

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for http_request_header_parser_core: random and directed request
// bytes, a scoreboard class that predicts every result beat. Depends on hrhp_pkg and hrhp_if.sv.
module tb;

    // One result beat as seen on the output channel.
    typedef struct {
        hrhp_pkg::t_kind   kind;
        logic [7:0]        data;
        logic              last;
        logic              done;
        hrhp_pkg::t_status status;
        hrhp_pkg::t_method method;
        logic              close;
        logic [31:0]       clen;
    } t_parse_beat;

    // Tracks the parser state and the result beats still owed by the block.
    class parse_scoreboard;
        t_parse_beat       expected_beats[$];
        int                errors;
        int                shown;

        hrhp_pkg::t_phase  phase;
        logic              cr_held;
        logic [3:0]        pos;
        logic [2:0]        cand;
        logic [2:0]        flags;
        hrhp_pkg::t_method meth;
        logic              close_seen;
        logic [31:0]       clen_acc;
        logic              finished;
        logic              step_done;
        hrhp_pkg::t_status step_status;

        string get_word   = "GET";
        string head_word  = "HEAD";
        string ver_word   = "HTTP/1.1";
        string close_word = "close";
        string key_word[3];

        function new();
            key_word = '{"Host", "Connection", "Content-Length"};
            errors   = 0;
            shown    = 0;
            clear_parser();
        endfunction

        function void clear_parser();
            phase      = hrhp_pkg::PH_METHOD;
            cr_held    = 1'b0;
            pos        = 4'd0;
            cand       = 3'b111;
            flags      = 3'b000;
            meth       = hrhp_pkg::METH_UNKNOWN;
            close_seen = 1'b0;
            clen_acc   = 32'd0;
            finished   = 1'b0;
        endfunction

        function void finish_parse(hrhp_pkg::t_status st);
            finished    = 1'b1;
            step_done   = 1'b1;
            step_status = st;
        endfunction

        function void start_key_line();
            phase = hrhp_pkg::PH_KEY;
            pos   = 4'd0;
            cand  = 3'b111;
            flags = 3'b000;
        endfunction

        function void bump();
            if (pos != 4'hF) pos++;
        endfunction

        // A byte of a header value after the leading spaces.
        function hrhp_pkg::t_kind value_byte(input logic [7:0] c, output logic [7:0] ob);
            logic [63:0] wide;
            ob = c;
            if (cand[hrhp_pkg::KEY_HOST]) return hrhp_pkg::KIND_HOST;
            if (cand[hrhp_pkg::KEY_CONN]) begin
                if (!(pos < 5 && c == close_word[pos])) flags[hrhp_pkg::FLAG_B] = 1'b1;
                bump();
            end
            if (cand[hrhp_pkg::KEY_CLEN]) begin
                if (!flags[hrhp_pkg::FLAG_C] && c >= hrhp_pkg::CH_ZERO
                        && c <= hrhp_pkg::CH_NINE) begin
                    wide = 64'(clen_acc) * 64'd10 + 64'(c - hrhp_pkg::CH_ZERO);
                    clen_acc = (wide > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
                end else begin
                    flags[hrhp_pkg::FLAG_C] = 1'b1;
                end
            end
            return hrhp_pkg::KIND_NONE;
        endfunction

        // A byte that is not part of a line end.
        function hrhp_pkg::t_kind plain_byte(input logic [7:0] c, output logic [7:0] ob);
            logic [2:0] sel;
            string      w;
            ob = 8'h00;
            case (phase)
                hrhp_pkg::PH_METHOD: begin
                    if (c == hrhp_pkg::CH_SP) begin
                        if (pos == 4'd3 && !flags[hrhp_pkg::FLAG_A]) begin
                            meth = hrhp_pkg::METH_GET;
                        end else if (pos == 4'd4 && !flags[hrhp_pkg::FLAG_B]) begin
                            meth = hrhp_pkg::METH_HEAD;
                        end else begin
                            meth = hrhp_pkg::METH_UNKNOWN;
                        end
                        phase = hrhp_pkg::PH_TARGET;
                        pos   = 4'd0;
                        flags = 3'b000;
                        return hrhp_pkg::KIND_NONE;
                    end
                    if (!(pos < 3 && c == get_word[pos])) flags[hrhp_pkg::FLAG_A] = 1'b1;
                    if (!(pos < 4 && c == head_word[pos])) flags[hrhp_pkg::FLAG_B] = 1'b1;
                    bump();
                    return hrhp_pkg::KIND_NONE;
                end
                hrhp_pkg::PH_TARGET: begin
                    if (c == hrhp_pkg::CH_SP) begin
                        phase = hrhp_pkg::PH_VERSION;
                        pos   = 4'd0;
                        flags = 3'b000;
                        return hrhp_pkg::KIND_NONE;
                    end
                    ob = c;
                    return hrhp_pkg::KIND_TARGET;
                end
                hrhp_pkg::PH_VERSION: begin
                    if (pos < 8 && c != ver_word[pos]) flags[hrhp_pkg::FLAG_A] = 1'b1;
                    bump();
                    return hrhp_pkg::KIND_NONE;
                end
                hrhp_pkg::PH_KEY: begin
                    if (c == hrhp_pkg::CH_COLON) begin
                        sel = 3'b000;
                        for (int k = 0; k < 3; k++) begin
                            w = key_word[k];
                            if (cand[k] && pos == w.len()) sel = 3'b001 << k;
                        end
                        cand  = sel;
                        pos   = 4'd0;
                        flags = 3'b000;
                        phase = hrhp_pkg::PH_VSKIP;
                        if (sel[hrhp_pkg::KEY_CLEN]) clen_acc = 32'd0;
                        return sel[hrhp_pkg::KEY_HOST] ? hrhp_pkg::KIND_RESTART
                                                       : hrhp_pkg::KIND_NONE;
                    end
                    for (int k = 0; k < 3; k++) begin
                        w = key_word[k];
                        if (!(pos < w.len() && w[pos] == c)) cand[k] = 1'b0;
                    end
                    bump();
                    return hrhp_pkg::KIND_NONE;
                end
                hrhp_pkg::PH_VSKIP: begin
                    if (c == hrhp_pkg::CH_SP) return hrhp_pkg::KIND_NONE;
                    phase = hrhp_pkg::PH_VALUE;
                    return value_byte(c, ob);
                end
                hrhp_pkg::PH_VALUE: return value_byte(c, ob);
                default: return hrhp_pkg::KIND_NONE;
            endcase
        endfunction

        // CR LF seen.
        function void line_end();
            case (phase)
                hrhp_pkg::PH_VERSION: begin
                    if (pos < 8 || flags[hrhp_pkg::FLAG_A]) finish_parse(hrhp_pkg::ST_VERSION);
                    else start_key_line();
                end
                hrhp_pkg::PH_KEY: begin
                    finish_parse(pos == 4'd0 ? hrhp_pkg::ST_OK : hrhp_pkg::ST_BAD);
                end
                hrhp_pkg::PH_VSKIP, hrhp_pkg::PH_VALUE: begin
                    if (cand[hrhp_pkg::KEY_CONN]) close_seen = !flags[hrhp_pkg::FLAG_B] && pos == 4'd5;
                    start_key_line();
                end
                default: ;
            endcase
        endfunction

        function void push_beat(hrhp_pkg::t_kind k, logic [7:0] d, logic last, logic done,
                                hrhp_pkg::t_status st);
            t_parse_beat e;
            e.kind   = k;
            e.data   = d;
            e.last   = last;
            e.done   = done;
            e.status = st;
            e.method = meth;
            e.close  = close_seen;
            e.clen   = clen_acc;
            expected_beats.push_back(e);
        endfunction

        // Accepted request byte; queues the result beats it causes.
        function void note_byte(logic [7:0] c, logic start);
            hrhp_pkg::t_kind kind;
            hrhp_pkg::t_kind rk;
            logic [7:0]      b;
            logic [7:0]      rb;
            if (start) clear_parser();
            step_done   = 1'b0;
            step_status = hrhp_pkg::ST_OK;
            if (finished) begin
                push_beat(hrhp_pkg::KIND_NONE, 8'h00, 1'b1, 1'b0, hrhp_pkg::ST_OK);
                return;
            end
            kind = hrhp_pkg::KIND_NONE;
            b    = 8'h00;
            if (c == hrhp_pkg::CH_NUL) begin
                cr_held = 1'b0;
                finish_parse(hrhp_pkg::ST_BAD);
            end else if (phase >= hrhp_pkg::PH_VERSION) begin
                if (cr_held) begin
                    cr_held = 1'b0;
                    if (c == hrhp_pkg::CH_LF) begin
                        line_end();
                    end else begin
                        // The held-back CR was an ordinary byte after all.
                        rk = plain_byte(hrhp_pkg::CH_CR, rb);
                        if (rk != hrhp_pkg::KIND_NONE)
                            push_beat(rk, rk == hrhp_pkg::KIND_RESTART ? 8'h00 : rb,
                                      1'b0, 1'b0, hrhp_pkg::ST_OK);
                        if (c == hrhp_pkg::CH_CR) cr_held = 1'b1;
                        else kind = plain_byte(c, b);
                    end
                end else if (c == hrhp_pkg::CH_CR) begin
                    cr_held = 1'b1;
                end else begin
                    kind = plain_byte(c, b);
                end
            end else begin
                kind = plain_byte(c, b);
            end
            if (kind == hrhp_pkg::KIND_NONE || kind == hrhp_pkg::KIND_RESTART) b = 8'h00;
            push_beat(kind, b, 1'b1, step_done, step_status);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                if (shown < 40) begin
                    shown++;
                    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                end
            end
        endfunction

        function void check_beat(t_parse_beat got);
            t_parse_beat e;
            if (expected_beats.size() == 0) begin
                errors++;
                if (shown < 40) begin
                    shown++;
                    $display("%0t: unexpected result beat, expected none, actual kind %0d byte %0h",
                             $time, got.kind, got.data);
                end
                return;
            end
            e = expected_beats.pop_front();
            compare_field("kind", e.kind, got.kind);
            compare_field("out_byte", e.data, got.data);
            compare_field("last", e.last, got.last);
            compare_field("done_res", e.done, got.done);
            compare_field("status", e.status, got.status);
            compare_field("method", e.method, got.method);
            compare_field("conn_close", e.close, got.close);
            compare_field("body_len", e.clen, got.clen);
        endfunction
    endclass

    localparam int ITEM_TARGET = 1050;
    localparam int CYCLE_LIMIT = 600000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    hrhp_byte_if byte_ch();
    hrhp_res_if  res_ch();

    http_request_header_parser_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .o_res   (res_ch)
    );

    parse_scoreboard sb = new();
    logic [7:0]      req_q[$];
    int              items_sent = 0;
    int              tx_mode = 0;
    int              rx_mode = 0;
    logic            rx_hold = 1'b0;
    int              cycle_count = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Mode 0 never waits; mode 1 waits at random; others wait now and then.
    function int draw_wait(int mode);
        if (mode == 0) return 0;
        if (mode == 1) return $urandom_range(0, 17);
        return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 17) : 0;
    endfunction

    function void add_text(string s);
        for (int i = 0; i < s.len(); i++) req_q.push_back(s[i]);
    endfunction

    function void add_crlf();
        req_q.push_back(hrhp_pkg::CH_CR);
        req_q.push_back(hrhp_pkg::CH_LF);
    endfunction

    function void add_random(int n, bit any_byte);
        for (int i = 0; i < n; i++)
            req_q.push_back(any_byte ? 8'($urandom_range(1, 255)) : 8'($urandom_range(33, 126)));
    endfunction

    function void add_digits(int n);
        for (int i = 0; i < n; i++)
            req_q.push_back(8'(hrhp_pkg::CH_ZERO + $urandom_range(0, 9)));
    endfunction

    // One header line, mostly well formed.
    function void add_header();
        string conn_vals[6];
        string odd_keys[7];
        conn_vals = '{"close", "closed", "clos", "keep-alive", "", "Close"};
        odd_keys  = '{"Hos", "host", "Connectio", "Connections", "Content-Lengt", "X-Id",
                      "Content-Length-Extra-X"};
        case ($urandom_range(0, 9))
            0, 1: begin
                add_text("Host:");
                add_text($urandom_range(0, 1) ? " " : "");
                // Host values carry lone CRs, including right after the colon.
                for (int j = $urandom_range(0, 6); j > 0; j--) begin
                    if ($urandom_range(0, 5) == 0) req_q.push_back(hrhp_pkg::CH_CR);
                    else req_q.push_back(8'($urandom_range(33, 126)));
                end
            end
            2, 3: begin
                add_text("Connection:");
                add_text($urandom_range(0, 1) ? " " : "  ");
                add_text(conn_vals[$urandom_range(0, 5)]);
            end
            4, 5: begin
                add_text("Content-Length:");
                add_text($urandom_range(0, 2) == 0 ? "" : " ");
                case ($urandom_range(0, 7))
                    0, 1: add_digits($urandom_range(1, 4));
                    2: add_digits($urandom_range(10, 14));
                    3: add_text("-5");
                    4: add_text("+7");
                    5: ;
                    6: begin
                        add_digits(2);
                        add_text("ab");
                        add_digits(2);
                    end
                    default: add_text($urandom_range(0, 1) ? "4294967295" : "4294967296");
                endcase
            end
            6: begin
                add_text(odd_keys[$urandom_range(0, 6)]);
                add_text(": ");
                add_random($urandom_range(0, 4), 1'b0);
            end
            7: begin
                // Key as long as or longer than the position counter can track.
                for (int j = $urandom_range(15, 20); j > 0; j--)
                    req_q.push_back(8'($urandom_range(65, 90)));
                add_text(":");
                add_random($urandom_range(0, 3), 1'b0);
            end
            8: add_random($urandom_range(1, 5), 1'b0);
            default: add_text("Host");
        endcase
        add_crlf();
    endfunction

    // A whole request, or now and then a run of arbitrary bytes.
    function void build_request();
        string ver_vals[7];
        ver_vals = '{"HTTP/1.1", "HTTP/1.1", "HTTP/1.1", "HTTP/1.0", "HTTP/1", "HTTP/1.1.2",
                     "http/1.1"};
        req_q.delete();
        if ($urandom_range(0, 6) == 0) begin
            for (int j = $urandom_range(1, 24); j > 0; j--)
                req_q.push_back(($urandom_range(0, 9) == 0) ? hrhp_pkg::CH_NUL
                                                            : 8'($urandom_range(1, 255)));
            return;
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3: add_text("GET");
            4, 5: add_text("HEAD");
            6: add_text("GETS");
            7: add_text("HEA");
            8: add_text("POST");
            default: add_random($urandom_range(0, 5), 1'b1);
        endcase
        add_text(" /");
        add_random($urandom_range(0, 5), $urandom_range(0, 3) == 0);
        add_text(" ");
        add_text(ver_vals[$urandom_range(0, 6)]);
        if ($urandom_range(0, 7) == 0) begin
            req_q.push_back(hrhp_pkg::CH_CR);
            add_text("x");
        end
        add_crlf();
        for (int h = $urandom_range(0, 3); h > 0; h--) add_header();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: add_crlf();
            7: req_q.push_back(hrhp_pkg::CH_NUL);
            8: ;
            default: begin
                add_crlf();
                add_random($urandom_range(1, 3), 1'b1);
            end
        endcase
    endfunction

    // Offer one request byte and wait until the block takes it.
    task automatic send_byte(logic [7:0] c, logic start);
        int gap;
        gap = draw_wait(tx_mode);
        if (gap > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.in_byte   <= c;
        byte_ch.start_req <= start;
        do @(posedge i_clk); while (!byte_ch.ready);
        sb.note_byte(c, start);
        items_sent++;
    endtask

    task automatic send_request();
        foreach (req_q[i]) send_byte(req_q[i], i == 0);
    endtask

    // Result side: random stalls, plus the long hold-off when requested.
    initial begin
        t_parse_beat got;
        int          stall;
        int          beats;
        beats = 0;
        res_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (beats % 40 == 0) rx_mode = $urandom_range(0, 3);
            stall = draw_wait(rx_mode);
            if (stall > 0 || rx_hold) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
                while (rx_hold) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
            got.kind   = res_ch.kind;
            got.data   = res_ch.out_byte;
            got.last   = res_ch.last;
            got.done   = res_ch.done_res;
            got.status = res_ch.status;
            got.method = res_ch.method;
            got.close  = res_ch.conn_close;
            got.clen   = res_ch.body_len;
            sb.check_beat(got);
            beats++;
        end
    end

    // Long hold-off on the result side while request bytes keep coming.
    initial begin
        wait (items_sent >= 400);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (150) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    initial begin
        i_rst_n           <= 1'b0;
        byte_ch.valid     <= 1'b0;
        byte_ch.in_byte   <= 8'h00;
        byte_ch.start_req <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: a byte before any start, end of buffer, a byte after the finish,
        // then a minimal HEAD request ending in an empty line.
        send_byte(8'hFF, 1'b0);
        send_byte(hrhp_pkg::CH_NUL, 1'b0);
        send_byte(8'hFF, 1'b0);
        req_q.delete();
        add_text("HEAD /a HTTP/1.1");
        add_crlf();
        add_crlf();
        send_request();

        // Random requests until enough bytes have been sent.
        while (items_sent < ITEM_TARGET) begin
            tx_mode = $urandom_range(0, 3);
            build_request();
            send_request();
        end
        byte_ch.valid <= 1'b0;

        while (sb.expected_beats.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_beats.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
design/hrhp_pkg.sv
design/hrhp_if.sv
design/http_request_header_parser_core.sv
tb/tb.sv
